// ===== hw/rtl/rscm_pkg.sv =====
package rscm_pkg;

    // Result status codes.
    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_COLOR   = 2'd2;

    localparam logic [15:0] AGE_WINDOW_RESET = 16'd3000;
    localparam logic [7:0]  CHANNEL_MAX      = 8'd255;

    localparam int TIME_W  = 32;
    localparam int RGB_W   = 24;
    localparam int ENTRY_W = TIME_W + RGB_W;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // Control from the sequencer to the mixing accumulator.
    typedef struct packed {
        logic clear;
        logic sample;
    } t_mix_ctrl;

    // Adds two channel values and clamps the result at full scale.
    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8] ? CHANNEL_MAX : sum[7:0];
    endfunction

endpackage

// ===== hw/rtl/rscm_ram.sv =====
module rscm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rscm_mix.sv =====
module rscm_mix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rscm_pkg::t_mix_ctrl   i_ctrl,
    input  logic [31:0]           i_now_ms,
    input  logic [15:0]           i_window,
    input  logic                  i_entry_valid,
    input  logic [31:0]           i_entry_time,
    input  rscm_pkg::t_rgb        i_entry_rgb,
    output rscm_pkg::t_rgb        o_mix_rgb,
    output logic                  o_seen
);
    import rscm_pkg::*;

    logic [31:0] age;
    logic        hit;
    t_rgb        r_sum;
    logic        r_seen;

    // Modular age, compared against the window as an unsigned 32-bit value.
    assign age = i_now_ms - i_entry_time;
    assign hit = i_entry_valid && (age < {16'd0, i_window});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_seen <= 1'b0;
        end else if (i_ctrl.sample && hit) begin
            r_seen <= 1'b1;
        end
    end

    // Saturating each step gives the same result as clamping the full sum.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_sum <= '0;
        end else if (i_ctrl.sample && hit) begin
            r_sum.r <= sat_add(r_sum.r, i_entry_rgb.r);
            r_sum.g <= sat_add(r_sum.g, i_entry_rgb.g);
            r_sum.b <= sat_add(r_sum.b, i_entry_rgb.b);
        end
    end

    assign o_mix_rgb = r_sum;
    assign o_seen    = r_seen;

endmodule

// ===== hw/rtl/recent_source_color_mixer.sv =====
// Channel   Direction  Handshake               Contents
// request   in         i_in_valid / o_in_stall  command, time, source id, colors
// result    out        o_out_valid / i_out_stall status, mixed color, recent flag
// config    in         i_cfg_wr_en             age window in milliseconds
//
// A packet writes its entry at acceptance and loads its result in FINISH. A query
// walks the entry RAM one entry per cycle in SCAN, passes DRAIN and loads its result
// in FINISH. Either waits in FINISH while an older result is stalled.
// One request is in work at a time; the next is taken once the result sits in the
// output register, even while it is stalled there. Reset (synchronous, active low)
// clears the valid bits, background and control state and sets the window to 3000 ms.
module recent_source_color_mixer #(
    parameter int NUM_SOURCES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration.
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // Request channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_source_id,
    input  logic        i_configure_flag,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [7:0]  i_bg_red_in,
    input  logic [7:0]  i_bg_green_in,
    input  logic [7:0]  i_bg_blue_in,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic        o_any_recent
);
    import rscm_pkg::*;

    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [IDX_W-1:0]       r_addr;
    logic [31:0]            r_now;
    logic                   r_is_query;
    logic [1:0]             r_pkt_status;
    logic [NUM_SOURCES-1:0] r_valid;
    t_rgb                   r_bg;
    logic [15:0]            r_window;
    logic                   r_rd_pending;
    logic                   r_rd_vld;

    logic                   r_out_valid;
    logic [1:0]             r_status;
    t_rgb                   r_rgb;
    logic                   r_recent;

    logic                   accept;
    logic                   in_range;
    logic                   store;
    logic                   out_free;
    logic                   last_addr;
    logic [IDX_W-1:0]       wr_idx;
    logic [ENTRY_W-1:0]     wr_entry;
    logic [ENTRY_W-1:0]     rd_entry;
    t_rgb                   rd_rgb;
    t_rgb                   mix_rgb;
    logic                   mix_seen;
    t_mix_ctrl              mix_ctrl;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign in_range   = ({1'b0, i_source_id} < 9'(NUM_SOURCES));
    assign store      = accept && !i_cmd && in_range;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign last_addr  = (r_addr == IDX_W'(NUM_SOURCES - 1));
    assign wr_idx     = i_source_id[IDX_W-1:0];
    assign wr_entry   = {i_now_ms, i_red_in, i_green_in, i_blue_in};

    // Time stamps and colors live in one RAM; valid bits stay in flip-flops
    // so that reset can clear them at once.
    rscm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SOURCES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (wr_idx),
        .i_wdata (wr_entry),
        .i_raddr (r_addr),
        .o_rdata (rd_entry)
    );

    assign rd_rgb          = rd_entry[RGB_W-1:0];
    assign mix_ctrl.clear  = accept && i_cmd;
    assign mix_ctrl.sample = r_rd_pending;

    rscm_mix u_mix (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (mix_ctrl),
        .i_now_ms      (r_now),
        .i_window      (r_window),
        .i_entry_valid (r_rd_vld),
        .i_entry_time  (rd_entry[ENTRY_W-1:RGB_W]),
        .i_entry_rgb   (rd_rgb),
        .o_mix_rgb     (mix_rgb),
        .o_seen        (mix_seen)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_cmd ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                if (last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, table valid bits, background and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_bg         <= '0;
            r_window     <= AGE_WINDOW_RESET;
            r_rd_pending <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_pending <= (r_state == S_SCAN);
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (store) begin
                r_valid[wr_idx] <= 1'b1;
                if (i_configure_flag) begin
                    r_bg <= '{r: i_bg_red_in, g: i_bg_green_in, b: i_bg_blue_in};
                end
            end
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request context, scan address and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now        <= i_now_ms;
            r_is_query   <= i_cmd;
            r_pkt_status <= in_range ? ST_STORED : ST_DROPPED;
            r_addr       <= '0;
        end else if (r_state == S_SCAN && !last_addr) begin
            r_addr <= r_addr + IDX_W'(1);
        end
        r_rd_vld <= r_valid[r_addr];
        if (r_state == S_FINISH && out_free) begin
            if (r_is_query) begin
                r_status <= ST_COLOR;
                r_rgb    <= mix_seen ? mix_rgb : r_bg;
                r_recent <= mix_seen;
            end else begin
                r_status <= r_pkt_status;
                r_rgb    <= '0;
                r_recent <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_red_out    = r_rgb.r;
    assign o_green_out  = r_rgb.g;
    assign o_blue_out   = r_rgb.b;
    assign o_any_recent = r_recent;

    // A packet result never carries a color or the recent flag.
    a_packet_result_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_COLOR) |->
            (o_red_out == 8'd0 && o_green_out == 8'd0 && o_blue_out == 8'd0
             && !o_any_recent))
        else $error("packet result carries color data");

    // The recent flag only appears on a color result.
    a_recent_is_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_any_recent) |-> (o_status == ST_COLOR))
        else $error("recent flag on a non-color result");

    // An accepted request keeps the sequencer busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("request accepted without entering work");

    // A query always walks the table before its result is loaded.
    a_query_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd) |=> (r_state == S_SCAN))
        else $error("query did not start a table scan");

endmodule
